// ===== design/bbk_pkg.sv =====
// Shared types, constants and helpers of the round beam-beam kick pipeline.
// Used by bbk_exp, bbk_div and round_beam_beam_kick; depends on nothing.
`default_nettype none

package bbk_pkg;

    localparam int ADDR_W    = 5;
    localparam int EXP_STEPS = 12;
    localparam int EXP_SQ    = 5;
    localparam int EXP_LAT   = 2 * EXP_STEPS + EXP_SQ + 1;
    localparam int DIV_BITS  = 32;
    localparam int DIV_LAT   = DIV_BITS + 1;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [60:0] HALF_Q30 = 61'h2000_0000;

    // ceil(2^34 / k): floor(x / k) = (x * RECIP[k]) >> 34 for x < 2^30
    localparam logic [33:0] RECIP [2:12] = '{
        34'd8589934592, 34'd5726623062, 34'd4294967296, 34'd3435973837,
        34'd2863311531, 34'd2454267027, 34'd2147483648, 34'd1908874354,
        34'd1717986919, 34'd1561806290, 34'd1431655766
    };

    typedef enum logic [2:0] {
        REG_OFFSET_X    = 3'd0,
        REG_OFFSET_Y    = 3'd1,
        REG_STRENGTH    = 3'd2,
        REG_INV_TWO_SIG = 3'd3,
        REG_KICK_OFF_X  = 3'd4,
        REG_KICK_OFF_Y  = 3'd5,
        REG_ROT_COS     = 3'd6,
        REG_ROT_SIN     = 3'd7
    } t_reg;

    typedef struct packed {
        logic signed [31:0] slope_x;
        logic signed [31:0] slope_y;
        logic signed [31:0] ratio;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic        [63:0] r2;
        logic               zero;
        logic               neg_x;
        logic               neg_y;
    } t_side;

    typedef struct packed {
        logic signed [31:0] new_slope_x;
        logic signed [31:0] new_slope_y;
        logic               skipped;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // (a + 2^29) >> 30 for a product of two Q0.30 values
    function automatic logic [30:0] exp_round(input logic [60:0] a);
        logic [61:0] s;
        s = 62'(a) + 62'(HALF_Q30);
        return s[60:30];
    endfunction

endpackage

`default_nettype wire

// ===== design/bbk_exp.sv =====
// Pipelined exp(-t): twelve Horner steps of two stages each, five squarings
// and a rounding stage. Depends on bbk_pkg.
`default_nettype none

module bbk_exp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [29:0]   i_f,
    input  wire logic          i_big,
    input  wire bbk_pkg::t_side i_side,
    output logic               o_valid,
    output logic [30:0]        o_e,
    output bbk_pkg::t_side     o_side
);
    import bbk_pkg::*;

    logic        r_v   [EXP_LAT];
    logic [29:0] r_f   [EXP_LAT];
    logic        r_big [EXP_LAT];
    logic [60:0] r_acc [EXP_LAT];
    t_side       r_side[EXP_LAT];

    logic        v_in   [EXP_LAT];
    logic [29:0] f_in   [EXP_LAT];
    logic        big_in [EXP_LAT];
    logic [60:0] acc_in [EXP_LAT];
    t_side       side_in[EXP_LAT];

    assign v_in[0]    = i_valid;
    assign f_in[0]    = i_f;
    assign big_in[0]  = i_big;
    assign acc_in[0]  = '0;
    assign side_in[0] = i_side;

    for (genvar j = 0; j < EXP_LAT; j++) begin : g_slot
        logic [60:0] n_val;

        if (j > 0) begin : g_link
            assign v_in[j]    = r_v[j-1];
            assign f_in[j]    = r_f[j-1];
            assign big_in[j]  = r_big[j-1];
            assign acc_in[j]  = r_acc[j-1];
            assign side_in[j] = r_side[j-1];
        end

        if (j < 2 * EXP_STEPS) begin : g_horner
            if (j % 2 == 0) begin : g_mul
                logic [30:0] p_in;
                if (j == 0) begin : g_first
                    assign p_in = ONE_Q30;
                end else begin : g_next
                    assign p_in = acc_in[j][30:0];
                end
                assign n_val = 61'(f_in[j]) * 61'(p_in);
            end else begin : g_div
                localparam int K = EXP_STEPS - j / 2;
                logic [29:0] x;
                logic [29:0] q;
                assign x = acc_in[j][59:30];
                if (K == 1) begin : g_one
                    assign q = x;
                end else begin : g_recip
                    logic [63:0] prod;
                    assign prod = 64'(x) * 64'(RECIP[K]);
                    assign q    = prod[63:34];
                end
                assign n_val = 61'(ONE_Q30 - 31'(q));
            end
        end else if (j < EXP_LAT - 1) begin : g_square
            logic [30:0] p_in;
            if (j == 2 * EXP_STEPS) begin : g_first
                assign p_in = acc_in[j][30:0];
            end else begin : g_next
                assign p_in = exp_round(acc_in[j]);
            end
            assign n_val = 61'(p_in) * 61'(p_in);
        end else begin : g_final
            // large exponent gives exactly zero
            assign n_val = big_in[j] ? 61'd0 : 61'(exp_round(acc_in[j]));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[j]    <= f_in[j];
                r_big[j]  <= big_in[j];
                r_acc[j]  <= n_val;
                r_side[j] <= side_in[j];
            end
        end
    end

    assign o_valid = r_v[EXP_LAT-1];
    assign o_e     = r_acc[EXP_LAT-1][30:0];
    assign o_side  = r_side[EXP_LAT-1];

endmodule

`default_nettype wire

// ===== design/bbk_div.sv =====
// Two-lane restoring divider, one quotient bit per stage: (num << 24) / r2,
// with an overflow flag when the quotient needs more than 32 bits.
// Depends on bbk_pkg.
`default_nettype none

module bbk_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [1:0][62:0] i_num,
    input  wire bbk_pkg::t_side   i_side,
    output logic                  o_valid,
    output logic [1:0][31:0]      o_quot,
    output logic [1:0]            o_ov,
    output bbk_pkg::t_side        o_side
);
    import bbk_pkg::*;

    logic             r_v   [DIV_LAT];
    logic [1:0][62:0] r_rem [DIV_LAT];
    logic [1:0][31:0] r_q   [DIV_LAT];
    logic [1:0][7:0]  r_lo  [DIV_LAT];
    logic [1:0]       r_ov  [DIV_LAT];
    t_side            r_side[DIV_LAT];

    for (genvar j = 0; j < DIV_LAT; j++) begin : g_slot
        logic [1:0][62:0] n_rem;
        logic [1:0][31:0] n_q;
        logic [1:0][7:0]  n_lo;
        logic [1:0]       n_ov;
        logic             v_in;
        t_side            side_in;

        if (j == 0) begin : g_head
            assign v_in    = i_valid;
            assign side_in = i_side;
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign n_ov[l]  = 72'(i_num[l]) >= {i_side.r2, 8'h00};
                assign n_rem[l] = 63'(i_num[l][62:8]);
                assign n_lo[l]  = i_num[l][7:0];
                assign n_q[l]   = '0;
            end
        end else begin : g_step
            localparam int I = j - 1;
            assign v_in    = r_v[j-1];
            assign side_in = r_side[j-1];
            for (genvar l = 0; l < 2; l++) begin : g_lane
                logic        b;
                logic [63:0] cand;
                logic        ge;
                if (I < 8) begin : g_bit
                    assign b = r_lo[j-1][l][7-I];
                end else begin : g_zero
                    assign b = 1'b0;
                end
                assign cand     = {r_rem[j-1][l], b};
                assign ge       = cand >= side_in.r2;
                assign n_rem[l] = ge ? 63'(cand - side_in.r2) : cand[62:0];
                assign n_q[l]   = {r_q[j-1][l][30:0], ge};
                assign n_lo[l]  = r_lo[j-1][l];
                assign n_ov[l]  = r_ov[j-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_q[j]    <= n_q;
                r_lo[j]   <= n_lo;
                r_ov[j]   <= n_ov;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_v[DIV_LAT-1];
    assign o_quot  = r_q[DIV_LAT-1];
    assign o_ov    = r_ov[DIV_LAT-1];
    assign o_side  = r_side[DIV_LAT-1];

endmodule

`default_nettype wire

// ===== design/round_beam_beam_kick.sv =====
// Top level of the round Gaussian beam-beam kick pipeline with its register port.
// Depends on bbk_pkg, bbk_exp and bbk_div.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one particle word per cycle while
//   o_stall is low: position, slope and momentum ratio. The output channel
//   (o_valid / i_stall) returns the kicked slopes and a skip flag, one word per
//   input, in order. Throughput is one word per cycle while nothing stalls. The
//   depth comes mostly from the exp pipeline (30 stages: twelve Horner steps of
//   two stages, five squarings, rounding) and the one-bit-per-stage divider
//   (33 stages).
//   The whole pipeline advances on one enable. Results land in an output
//   register backed by a skid register; o_stall rises only when both hold a
//   word, so a stalled receiver costs nothing until the skid fills, and then
//   the pipeline freezes without losing or repeating a word. o_stall is a
//   register output and never depends on i_valid.
//   Reset (synchronous, active low) clears all valid bits and loads the
//   register defaults: inv_two_sigma_sq = 1.0, rot_cos = 1.0, others zero.
//   Registers are written through the APB port (4 bytes each, pready always
//   high) and must only change while the pipeline is empty.
`default_nettype none

module round_beam_beam_kick (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // register port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bbk_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // particle input
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic signed [31:0]          i_pos_x,
    input  wire logic signed [31:0]          i_pos_y,
    input  wire logic signed [31:0]          i_slope_x,
    input  wire logic signed [31:0]          i_slope_y,
    input  wire logic signed [31:0]          i_momentum_ratio,
    // kicked output
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [31:0]               o_new_slope_x,
    output logic signed [31:0]               o_new_slope_y,
    output logic                             o_skipped
);
    import bbk_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_off_x, r_off_y, r_strength;
    logic        [31:0] r_inv;
    logic signed [31:0] r_kick_x, r_kick_y, r_cos, r_sin;

    logic  w_wr;
    t_reg  w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = t_reg'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_strength <= '0;
            r_inv      <= 32'h0100_0000;
            r_kick_x   <= '0;
            r_kick_y   <= '0;
            r_cos      <= 32'sh4000_0000;
            r_sin      <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_OFFSET_X:    r_off_x    <= pwdata;
                REG_OFFSET_Y:    r_off_y    <= pwdata;
                REG_STRENGTH:    r_strength <= pwdata;
                REG_INV_TWO_SIG: r_inv      <= pwdata;
                REG_KICK_OFF_X:  r_kick_x   <= pwdata;
                REG_KICK_OFF_Y:  r_kick_y   <= pwdata;
                REG_ROT_COS:     r_cos      <= pwdata;
                REG_ROT_SIN:     r_sin      <= pwdata;
                default:         r_off_x    <= r_off_x;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_OFFSET_X:    prdata = r_off_x;
            REG_OFFSET_Y:    prdata = r_off_y;
            REG_STRENGTH:    prdata = r_strength;
            REG_INV_TWO_SIG: prdata = r_inv;
            REG_KICK_OFF_X:  prdata = r_kick_x;
            REG_KICK_OFF_Y:  prdata = r_kick_y;
            REG_ROT_COS:     prdata = r_cos;
            REG_ROT_SIN:     prdata = r_sin;
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline enable ----------------
    // Every stage moves together; hold everything while the skid is full.
    t_res  r_out, r_skid;
    logic  r_ov, r_sv;
    logic  w_en;

    assign w_en    = !r_sv;
    assign o_stall = r_sv;

    // ---------------- front: offset, rotate, radius ----------------
    logic               r_s1_v;
    logic signed [31:0] r_s1_dx, r_s1_dy;
    t_side              r_s1_side;

    logic               r_s2_v;
    logic signed [63:0] r_s2_dxc, r_s2_dys, r_s2_dyc, r_s2_dxs;
    t_side              r_s2_side;

    logic               r_s3_v;
    t_side              r_s3_side;

    logic               r_s4_v;
    logic signed [63:0] r_s4_uu, r_s4_vv;
    t_side              r_s4_side;

    logic               r_s5_v;
    t_side              r_s5_side;

    logic               r_s6_v;
    logic        [63:0] r_s6_am, r_s6_bm;
    t_side              r_s6_side;

    t_side n_s1_side, n_s3_side, n_s5_side;

    always_comb begin
        n_s1_side         = '0;
        n_s1_side.slope_x = i_slope_x;
        n_s1_side.slope_y = i_slope_y;
        n_s1_side.ratio   = i_momentum_ratio;

        n_s3_side   = r_s2_side;
        n_s3_side.u = sat32((r_s2_dxc >>> 30) + (r_s2_dys >>> 30));
        n_s3_side.v = sat32((r_s2_dyc >>> 30) - (r_s2_dxs >>> 30));

        n_s5_side      = r_s4_side;
        n_s5_side.r2   = unsigned'(r_s4_uu) + unsigned'(r_s4_vv);
        n_s5_side.zero = (n_s5_side.r2 == 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dx   <= sat32(64'(i_pos_x) + 64'(r_off_x));
            r_s1_dy   <= sat32(64'(i_pos_y) + 64'(r_off_y));
            r_s1_side <= n_s1_side;

            r_s2_dxc  <= 64'(r_s1_dx) * 64'(r_cos);
            r_s2_dys  <= 64'(r_s1_dy) * 64'(r_sin);
            r_s2_dyc  <= 64'(r_s1_dy) * 64'(r_cos);
            r_s2_dxs  <= 64'(r_s1_dx) * 64'(r_sin);
            r_s2_side <= r_s1_side;

            r_s3_side <= n_s3_side;

            r_s4_uu   <= 64'(r_s3_side.u) * 64'(r_s3_side.u);
            r_s4_vv   <= 64'(r_s3_side.v) * 64'(r_s3_side.v);
            r_s4_side <= r_s3_side;

            r_s5_side <= n_s5_side;

            r_s6_am   <= 64'(r_s5_side.r2[63:32]) * 64'(r_inv);
            r_s6_bm   <= 64'(r_s5_side.r2[31:0]) * 64'(r_inv);
            r_s6_side <= r_s5_side;
        end
    end

    // ---------------- exponent: t = r2 * inv / 2^48 ----------------
    logic [48:0] w_t;
    logic [32:0] w_t_lo;
    logic        w_big;
    logic [29:0] w_f;

    assign w_t_lo = 33'(r_s6_am[15:0]) + 33'(r_s6_bm[63:32]);
    assign w_t    = 49'(r_s6_am[63:16]) + 49'(w_t_lo[32:16]);
    assign w_big  = |w_t[48:29];      // t >= 32.0 in Q25.24
    assign w_f    = {w_t[28:0], 1'b0};  // t / 32 in Q0.30

    logic        w_exp_v;
    logic [30:0] w_exp_e;
    t_side       w_exp_side;

    bbk_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s6_v),
        .i_f     (w_f),
        .i_big   (w_big),
        .i_side  (r_s6_side),
        .o_valid (w_exp_v),
        .o_e     (w_exp_e),
        .o_side  (w_exp_side)
    );

    // ---------------- strength scaling, numerators ----------------
    logic               r_s8_v;
    logic signed [63:0] r_s8_prod;
    t_side              r_s8_side;

    logic               r_s9_v;
    logic [1:0][62:0]   r_s9_num;
    t_side              r_s9_side;

    logic signed [31:0] w_one_minus_e;
    logic signed [63:0] w_s1_wide;
    logic signed [31:0] w_s1;
    logic        [31:0] w_abs_s1, w_abs_u, w_abs_v;
    t_side              n_s9_side;

    assign w_one_minus_e = signed'(32'(ONE_Q30 - w_exp_e));
    assign w_s1_wide     = r_s8_prod >>> 30;
    assign w_s1          = w_s1_wide[31:0];
    assign w_abs_s1      = w_s1[31] ? 32'(-w_s1) : 32'(w_s1);
    assign w_abs_u       = r_s8_side.u[31] ? 32'(-r_s8_side.u) : 32'(r_s8_side.u);
    assign w_abs_v       = r_s8_side.v[31] ? 32'(-r_s8_side.v) : 32'(r_s8_side.v);

    always_comb begin
        n_s9_side       = r_s8_side;
        n_s9_side.neg_x = w_s1[31] != r_s8_side.u[31];
        n_s9_side.neg_y = w_s1[31] != r_s8_side.v[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
            r_s9_v <= 1'b0;
        end else if (w_en) begin
            r_s8_v <= w_exp_v;
            r_s9_v <= r_s8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_prod   <= 64'(r_strength) * 64'(w_one_minus_e);
            r_s8_side   <= w_exp_side;
            r_s9_num[0] <= 63'(64'(w_abs_s1) * 64'(w_abs_u));
            r_s9_num[1] <= 63'(64'(w_abs_s1) * 64'(w_abs_v));
            r_s9_side   <= n_s9_side;
        end
    end

    // ---------------- kick quotient ----------------
    logic             w_div_v;
    logic [1:0][31:0] w_quot;
    logic [1:0]       w_ovf;
    t_side            w_div_side;

    bbk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s9_v),
        .i_num   (r_s9_num),
        .i_side  (r_s9_side),
        .o_valid (w_div_v),
        .o_quot  (w_quot),
        .o_ov    (w_ovf),
        .o_side  (w_div_side)
    );

    // signed, saturated kick per lane
    logic [1:0][31:0]        w_mag;
    logic signed [1:0][31:0] w_kick;
    logic [1:0]              w_neg;

    assign w_neg = {w_div_side.neg_y, w_div_side.neg_x};

    for (genvar l = 0; l < 2; l++) begin : g_kick
        assign w_mag[l]  = (w_ovf[l] || w_quot[l] > 32'h8000_0000) ? 32'h8000_0000
                                                                   : w_quot[l];
        assign w_kick[l] = w_neg[l] ? signed'(32'(-w_mag[l]))
                         : (w_mag[l][31] ? 32'sh7FFF_FFFF : signed'(w_mag[l]));
    end

    // ---------------- back: subtract orbit kick, rotate back, scale ----------------
    logic               r_s10_v;
    logic signed [31:0] r_s10_gx, r_s10_gy;
    t_side              r_s10_side;

    logic               r_s11_v;
    logic signed [63:0] r_s11_gxc, r_s11_gys, r_s11_gxs, r_s11_gyc;
    t_side              r_s11_side;

    logic               r_s12_v;
    logic signed [31:0] r_s12_wx, r_s12_wy;
    t_side              r_s12_side;

    logic               r_s13_v;
    logic signed [63:0] r_s13_px, r_s13_py;
    t_side              r_s13_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_v <= 1'b0;
            r_s11_v <= 1'b0;
            r_s12_v <= 1'b0;
            r_s13_v <= 1'b0;
        end else if (w_en) begin
            r_s10_v <= w_div_v;
            r_s11_v <= r_s10_v;
            r_s12_v <= r_s11_v;
            r_s13_v <= r_s12_v;
        end
    end

    // an element of the packed kick array reads as unsigned; sign it first
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s10_gx   <= sat32(64'(signed'(w_kick[0])) - 64'(r_kick_x));
            r_s10_gy   <= sat32(64'(signed'(w_kick[1])) - 64'(r_kick_y));
            r_s10_side <= w_div_side;

            r_s11_gxc  <= 64'(r_s10_gx) * 64'(r_cos);
            r_s11_gys  <= 64'(r_s10_gy) * 64'(r_sin);
            r_s11_gxs  <= 64'(r_s10_gx) * 64'(r_sin);
            r_s11_gyc  <= 64'(r_s10_gy) * 64'(r_cos);
            r_s11_side <= r_s10_side;

            r_s12_wx   <= sat32((r_s11_gxc >>> 30) - (r_s11_gys >>> 30));
            r_s12_wy   <= sat32((r_s11_gxs >>> 30) + (r_s11_gyc >>> 30));
            r_s12_side <= r_s11_side;

            r_s13_px   <= 64'(r_s12_wx) * 64'(r_s12_side.ratio);
            r_s13_py   <= 64'(r_s12_wy) * 64'(r_s12_side.ratio);
            r_s13_side <= r_s12_side;
        end
    end

    // final add; zero radius passes the slopes through untouched
    t_res w_res;

    always_comb begin
        w_res.skipped = r_s13_side.zero;
        if (r_s13_side.zero) begin
            w_res.new_slope_x = r_s13_side.slope_x;
            w_res.new_slope_y = r_s13_side.slope_y;
        end else begin
            w_res.new_slope_x = sat32(64'(r_s13_side.slope_x) + (r_s13_px >>> 30));
            w_res.new_slope_y = sat32(64'(r_s13_side.slope_y) + (r_s13_py >>> 30));
        end
    end

    // ---------------- output register and skid ----------------
    logic w_push, w_pop;

    assign w_push = w_en && r_s13_v;
    assign w_pop  = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_push) begin
            if (!r_ov || w_pop) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_pop) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            if (!r_ov || w_pop) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_pop && r_sv) begin
            r_out <= r_skid;
        end
    end

    assign o_valid       = r_ov;
    assign o_new_slope_x = r_out.new_slope_x;
    assign o_new_slope_y = r_out.new_slope_y;
    assign o_skipped     = r_out.skipped;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a word while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(i_stall))
        else $error("skid filled without a receiver stall");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exp_v |-> (w_exp_e <= ONE_Q30))
        else $error("exp result above one");

endmodule

`default_nettype wire
